### rtl/sprite_pixel_generator_unit_macros.svh
// Assertion macros used by the sprite pixel generator checker.
`ifndef SPRITE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define SPRITE_PIXEL_GENERATOR_UNIT_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define SPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite pixel generator check failed");

// Checks the consequent in the cycle after the antecedent.
`define SPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite pixel generator check failed");

`endif

### rtl/spg_pkg.sv
// Types and constants of the sprite pixel generator.
package spg_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 3;
    localparam int WORD_W   = 16;
    localparam int HPOS_W   = 9;
    localparam int PIXEL_W  = 2;
    localparam int SPAN_W   = $clog2(WORD_W);
    localparam int XPOS_W   = 8;
    localparam int ATTACH_BIT = 7;

    localparam logic [ACTION_W-1:0] ACT_CTRL  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic              ctrl_we;
        logic              data_we;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } spg_wr_t;

endpackage

### rtl/spg_in_if.sv
// Request channel carrying register writes and pixel queries.
interface spg_in_if;
    import spg_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  sprite_index;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
    logic [HPOS_W-1:0]   hpos;

    modport source (
        output valid, action, sprite_index, word_a, word_b, hpos,
        input  ready
    );

    modport sink (
        input  valid, action, sprite_index, word_a, word_b, hpos,
        output ready
    );
endinterface

### rtl/spg_out_if.sv
// Response channel carrying the pixel and attach flag of each item.
interface spg_out_if;
    import spg_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               attached;

    modport source (
        output valid, pixel, attached,
        input  ready
    );

    modport sink (
        input  valid, pixel, attached,
        output ready
    );
endinterface

### rtl/sprite_pixel_generator_unit.sv
// Sprite pixel generator: SPRITE_COUNT two-plane, 16-pixel-wide sprite channels. Each request
// item is a control write, a data write or a pixel query, and each gives exactly one response
// item with the 2-bit pixel (zero on writes and outside the sprite) and the attach flag of the
// addressed odd channel. One item is accepted every clock while the response side keeps up; an
// item passes an input register and then a response register, which holds its response. Writes
// take effect for every item accepted after them.
module sprite_pixel_generator_unit #(
    parameter int SPRITE_COUNT = 8
) (
    input logic        clk,
    input logic        rst_n,
    spg_in_if.sink     req,
    spg_out_if.source  rsp
);
    import spg_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    logic [WORD_W-1:0]   s1_word_a_reg;
    logic [WORD_W-1:0]   s1_word_b_reg;
    logic [HPOS_W-1:0]   s1_hpos_reg;
    logic                s1_advance;
    logic                take;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [PIXEL_W-1:0]  out_pixel_reg;
    logic [PIXEL_W-1:0]  out_pixel_next;
    logic                out_attached_reg;
    logic                out_attached_next;

    logic [SPRITE_COUNT-1:0] hit;
    logic [PIXEL_W-1:0]      ch_pixel [SPRITE_COUNT];
    logic [SPRITE_COUNT-1:0] ch_attached;
    logic [PIXEL_W-1:0]      pixel_sel;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready     = !s1_valid_reg || !out_valid_reg || rsp.ready;
    assign take          = req.valid && req.ready;
    assign s1_valid_next = take || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_action_reg <= req.action;
            s1_index_reg  <= req.sprite_index;
            s1_word_a_reg <= req.word_a;
            s1_word_b_reg <= req.word_b;
            s1_hpos_reg   <= req.hpos;
        end
    end

    // Channel state is written as the item leaves the input register.
    genvar i;
    generate
        for (i = 0; i < SPRITE_COUNT; i++)
        begin : g_ch
            spg_wr_t wr;

            assign hit[i]     = (int'(s1_index_reg) == i);
            assign wr.ctrl_we = s1_advance && hit[i] && (s1_action_reg == ACT_CTRL);
            assign wr.data_we = s1_advance && hit[i] && (s1_action_reg == ACT_DATA);
            assign wr.word_a  = s1_word_a_reg;
            assign wr.word_b  = s1_word_b_reg;

            spg_channel #(
                .HAS_ATTACH (bit'(i % 2))
            ) u_channel (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr       (wr),
                .hpos     (s1_hpos_reg),
                .pixel    (ch_pixel[i]),
                .attached (ch_attached[i])
            );
        end
    endgenerate

    always_comb
    begin
        pixel_sel = '0;
        for (int k = 0; k < SPRITE_COUNT; k++)
        begin
            pixel_sel = pixel_sel | (ch_pixel[k] & {PIXEL_W{hit[k]}});
        end
    end

    assign out_pixel_next    = (s1_action_reg == ACT_QUERY) ? pixel_sel : '0;
    assign out_attached_next = |(ch_attached & hit);
    assign out_valid_next    = s1_advance || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_pixel_reg    <= out_pixel_next;
            out_attached_reg <= out_attached_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.pixel    = out_pixel_reg;
    assign rsp.attached = out_attached_reg;

endmodule

### rtl/spg_channel.sv
// One sprite channel: its registers and its horizontal window match.
module spg_channel #(
    parameter bit HAS_ATTACH = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spg_pkg::spg_wr_t              wr,
    input  logic [spg_pkg::HPOS_W-1:0]    hpos,
    output logic [spg_pkg::PIXEL_W-1:0]   pixel,
    output logic                          attached
);
    import spg_pkg::*;

    logic [HPOS_W-1:0] hstart_reg;
    logic [HPOS_W-1:0] hstart_next;
    logic              armed_reg;
    logic              armed_next;
    logic [WORD_W-1:0] plane_a_reg;
    logic [WORD_W-1:0] plane_a_next;
    logic [WORD_W-1:0] plane_b_reg;
    logic [WORD_W-1:0] plane_b_next;
    logic [HPOS_W:0]   offset;
    logic [SPAN_W-1:0] bit_sel;
    logic              in_window;

    // The start position is the position low byte followed by control bit 0.
    assign hstart_next  = wr.ctrl_we ? {wr.word_a[XPOS_W-1:0], wr.word_b[0]} : hstart_reg;
    assign armed_next   = armed_reg | wr.ctrl_we;
    assign plane_a_next = wr.data_we ? wr.word_a : plane_a_reg;
    assign plane_b_next = wr.data_we ? wr.word_b : plane_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hstart_reg  <= '0;
            armed_reg   <= 1'b0;
            plane_a_reg <= '0;
            plane_b_reg <= '0;
        end
        else
        begin
            hstart_reg  <= hstart_next;
            armed_reg   <= armed_next;
            plane_a_reg <= plane_a_next;
            plane_b_reg <= plane_b_next;
        end
    end

    // The window is compared at full width, so it never wraps past the line end.
    assign offset    = {1'b0, hpos} - {1'b0, hstart_reg};
    assign in_window = armed_reg && !offset[HPOS_W] && (offset[HPOS_W-1:SPAN_W] == '0);
    assign bit_sel   = ~offset[SPAN_W-1:0];
    assign pixel     = in_window ? {plane_b_reg[bit_sel], plane_a_reg[bit_sel]} : '0;

    generate
        if (HAS_ATTACH)
        begin : g_attach
            logic attach_reg;
            logic attach_next;

            assign attach_next = wr.ctrl_we ? wr.word_b[ATTACH_BIT] : attach_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    attach_reg <= 1'b0;
                end
                else
                begin
                    attach_reg <= attach_next;
                end
            end

            // The reported flag already includes this item's own update.
            assign attached = attach_next;
        end
        else
        begin : g_no_attach
            assign attached = 1'b0;
        end
    endgenerate

endmodule

### rtl/spg_checker.sv
// Port-level checks of the sprite pixel generator, bound to its top level.
`include "sprite_pixel_generator_unit_macros.svh"

module spg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [spg_pkg::ACTION_W-1:0]  req_action,
    input logic [spg_pkg::INDEX_W-1:0]   req_sprite_index,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [spg_pkg::PIXEL_W-1:0]   rsp_pixel,
    input logic                          rsp_attached
);
    import spg_pkg::*;

    // A stalled response holds.
    `SPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel) && $stable(rsp_attached))

    // A response only goes away after it was taken.
    `SPG_ASSERT_NOW(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready))

    // With the response side ready, an accepted item shows up once it has passed its input and response registers.
    `SPG_ASSERT_NEXT(a_latency, (req_valid && req_ready && rsp_ready) ##1 rsp_ready, rsp_valid)

    // Writes and unused codes never report a pixel.
    `SPG_ASSERT_NEXT(a_write_pixel, (req_valid && req_ready && rsp_ready && req_action != ACT_QUERY) ##1 rsp_ready, rsp_pixel == '0)

    // Even channels never report the attach flag.
    `SPG_ASSERT_NEXT(a_even_attach, (req_valid && req_ready && rsp_ready && !req_sprite_index[0]) ##1 rsp_ready, !rsp_attached)

endmodule

bind sprite_pixel_generator_unit spg_checker u_spg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_action       (req.action),
    .req_sprite_index (req.sprite_index),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_pixel        (rsp.pixel),
    .rsp_attached     (rsp.attached)
);
